FILE: sv/grt2x_pkg.sv
// ----------------------------------------------------------------------------
// grt2x_pkg
// Shared widths and codes for the trilinear 2x grid refinement core.
// ----------------------------------------------------------------------------
package grt2x_pkg;

  localparam int VALUE_W  = 32;
  localparam int SIZE_W   = 5;
  localparam int INDEX_W  = 5;
  localparam int COORD_W  = 4;
  localparam int BANK_AW  = 3 * (COORD_W - 1);
  localparam int N_BANKS  = 8;
  localparam int CFG_IW   = 2;
  localparam int PAIR_W   = VALUE_W + 1;
  localparam int SUM_W    = VALUE_W + 3;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [BANK_AW-1:0]        bank_addr_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_SIZE_I = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SIZE_J = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SIZE_K = 2'd2;

  localparam logic [SIZE_W-1:0] MAX_EDGE = 5'd16;

endpackage

FILE: sv/grt2x_bank.sv
// ----------------------------------------------------------------------------
// grt2x_bank
// One parity bank of the coarse node store: one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module grt2x_bank (
  input  logic                  clk,
  input  logic                  we,
  input  grt2x_pkg::bank_addr_t waddr,
  input  grt2x_pkg::value_t     wdata,
  input  grt2x_pkg::bank_addr_t raddr,
  output grt2x_pkg::value_t     rdata
);

  grt2x_pkg::value_t mem [2**grt2x_pkg::BANK_AW];
  grt2x_pkg::value_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/grid_refine_trilinear_2x_core.sv
// ----------------------------------------------------------------------------
// grid_refine_trilinear_2x_core
// Stores coarse node values and returns trilinear 2x refined node values.
// ----------------------------------------------------------------------------
// The core takes one request per clock cycle whenever busy is low; busy is
// high only during reset and in the first cycle after it. A write request
// stores a coarse node and gives no result. A query request gives its result
// on out_valid through the bank read, pair sum and output registers, and the
// result cannot be held off. The rate is set by the coarse store, which is
// split into eight banks by the parity of the coarse indices so that all
// eight corners of a fine node are read in one cycle. The store is not
// cleared by reset; only written nodes may be queried.
module grid_refine_trilinear_2x_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_op,
  input  logic [grt2x_pkg::INDEX_W-1:0]          in_index_i,
  input  logic [grt2x_pkg::INDEX_W-1:0]          in_index_j,
  input  logic [grt2x_pkg::INDEX_W-1:0]          in_index_k,
  input  logic signed [grt2x_pkg::VALUE_W-1:0]   in_node_value,
  output logic                                   out_valid,
  output logic signed [grt2x_pkg::VALUE_W-1:0]   out_fine_value,
  output logic                                   out_out_of_range,
  input  logic                                   cfg_we,
  input  logic [grt2x_pkg::CFG_IW-1:0]           cfg_index,
  input  logic [grt2x_pkg::SIZE_W-1:0]           cfg_data
);

  function automatic logic [grt2x_pkg::SIZE_W-1:0] sat_size(
    input logic [grt2x_pkg::SIZE_W-1:0] raw
  );
    logic [grt2x_pkg::SIZE_W-1:0] v;
    v = raw;
    if (raw == '0) begin
      v = grt2x_pkg::SIZE_W'(1);
    end else if (raw > grt2x_pkg::MAX_EDGE) begin
      v = grt2x_pkg::MAX_EDGE;
    end
    return v;
  endfunction

  function automatic logic out_of_grid(
    input logic [grt2x_pkg::INDEX_W-1:0] f,
    input logic [grt2x_pkg::SIZE_W-1:0]  n
  );
    logic [grt2x_pkg::SIZE_W:0] lim;
    lim = {n, 1'b0} - (grt2x_pkg::SIZE_W+1)'(1);
    return {1'b0, f} >= lim;
  endfunction

  logic [grt2x_pkg::SIZE_W-1:0] size_i_r, size_j_r, size_k_r;
  logic                         busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_i_r <= grt2x_pkg::MAX_EDGE;
      size_j_r <= grt2x_pkg::MAX_EDGE;
      size_k_r <= grt2x_pkg::SIZE_W'(1);
      busy_r   <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          grt2x_pkg::CFG_SIZE_I: size_i_r <= sat_size(cfg_data);
          grt2x_pkg::CFG_SIZE_J: size_j_r <= sat_size(cfg_data);
          grt2x_pkg::CFG_SIZE_K: size_k_r <= sat_size(cfg_data);
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  logic accept, is_query, wr_en, flag_s0;
  logic [grt2x_pkg::COORD_W-1:0] lo_i, lo_j, lo_k;
  logic [grt2x_pkg::COORD_W-1:0] ci [2];
  logic [grt2x_pkg::COORD_W-1:0] cj [2];
  logic [grt2x_pkg::COORD_W-1:0] ck [2];
  logic [1:0] ui, uj, uk;
  logic [grt2x_pkg::N_BANKS-1:0] used_s0;
  logic [1:0] shift_s0;
  logic [2:0] wr_bank;
  grt2x_pkg::bank_addr_t wr_addr;
  grt2x_pkg::bank_addr_t rd_addr [grt2x_pkg::N_BANKS];
  grt2x_pkg::value_t     rd_data [grt2x_pkg::N_BANKS];

  assign accept   = start && !busy_r;
  assign is_query = (in_op == grt2x_pkg::OP_QUERY);

  assign lo_i = in_index_i[grt2x_pkg::INDEX_W-1:1];
  assign lo_j = in_index_j[grt2x_pkg::INDEX_W-1:1];
  assign lo_k = in_index_k[grt2x_pkg::INDEX_W-1:1];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      ci[p] = (lo_i[0] == p[0]) ? lo_i : lo_i + grt2x_pkg::COORD_W'(1);
      cj[p] = (lo_j[0] == p[0]) ? lo_j : lo_j + grt2x_pkg::COORD_W'(1);
      ck[p] = (lo_k[0] == p[0]) ? lo_k : lo_k + grt2x_pkg::COORD_W'(1);
      ui[p] = (lo_i[0] == p[0]) || in_index_i[0];
      uj[p] = (lo_j[0] == p[0]) || in_index_j[0];
      uk[p] = (lo_k[0] == p[0]) || in_index_k[0];
    end
  end

  assign shift_s0 = 2'(in_index_i[0]) + 2'(in_index_j[0]) + 2'(in_index_k[0]);
  assign flag_s0  = out_of_grid(in_index_i, size_i_r) || out_of_grid(in_index_j, size_j_r)
                 || out_of_grid(in_index_k, size_k_r);

  assign wr_en   = accept && (in_op == grt2x_pkg::OP_WRITE) && (in_index_i < size_i_r)
                && (in_index_j < size_j_r) && (in_index_k < size_k_r);
  assign wr_bank = {in_index_k[0], in_index_j[0], in_index_i[0]};
  assign wr_addr = {in_index_k[grt2x_pkg::COORD_W-1:1], in_index_j[grt2x_pkg::COORD_W-1:1],
                    in_index_i[grt2x_pkg::COORD_W-1:1]};

  for (genvar b = 0; b < grt2x_pkg::N_BANKS; b++) begin : g_bank
    assign rd_addr[b] = {ck[b/4][grt2x_pkg::COORD_W-1:1], cj[(b/2)%2][grt2x_pkg::COORD_W-1:1],
                         ci[b%2][grt2x_pkg::COORD_W-1:1]};
    assign used_s0[b] = ui[b%2] && uj[(b/2)%2] && uk[b/4];

    grt2x_bank u_bank (
      .clk   (clk),
      .we    (wr_en && (wr_bank == 3'(b))),
      .waddr (wr_addr),
      .wdata (in_node_value),
      .raddr (rd_addr[b]),
      .rdata (rd_data[b])
    );
  end

  logic                           v1_r, v2_r, out_valid_r;
  logic                           flag1_r, flag2_r, out_flag_r;
  logic [1:0]                     shift1_r, shift2_r;
  logic [grt2x_pkg::N_BANKS-1:0]  used1_r;
  logic signed [grt2x_pkg::PAIR_W-1:0] pair_r [grt2x_pkg::N_BANKS/2];
  logic signed [grt2x_pkg::PAIR_W-1:0] pair_nxt [grt2x_pkg::N_BANKS/2];
  logic signed [grt2x_pkg::SUM_W-1:0]  total;
  logic signed [grt2x_pkg::SUM_W-1:0]  scaled;
  grt2x_pkg::value_t                   out_value_r;
  grt2x_pkg::value_t                   out_value_nxt;

  always_comb begin
    for (int m = 0; m < grt2x_pkg::N_BANKS/2; m++) begin
      pair_nxt[m] =
        (used1_r[2*m]   ? grt2x_pkg::PAIR_W'(rd_data[2*m])   : '0) +
        (used1_r[2*m+1] ? grt2x_pkg::PAIR_W'(rd_data[2*m+1]) : '0);
    end
    total = grt2x_pkg::SUM_W'(pair_r[0]) + grt2x_pkg::SUM_W'(pair_r[1])
          + grt2x_pkg::SUM_W'(pair_r[2]) + grt2x_pkg::SUM_W'(pair_r[3]);
    scaled = total >>> shift2_r;
    out_value_nxt = flag2_r ? '0 : scaled[grt2x_pkg::VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept && is_query;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    flag1_r    <= flag_s0;
    shift1_r   <= shift_s0;
    used1_r    <= used_s0;
    flag2_r    <= flag1_r;
    shift2_r   <= shift1_r;
    pair_r     <= pair_nxt;
    out_flag_r <= flag2_r;
    out_value_r <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_fine_value   = out_value_r;
  assign out_out_of_range = out_valid_r && out_flag_r;

`ifndef NO_ASSERTIONS
  a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_query) |-> ##3 out_valid)
    else $error("query request produced no result");

  a_result_has_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_op == grt2x_pkg::OP_QUERY, 3))
    else $error("result without a query request");

  a_flag_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_out_of_range |-> (out_valid && out_fine_value == '0))
    else $error("flagged result carries a value");

  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("request taken in the cycle after reset");
`endif

endmodule
